>>> src/qe_pkg.sv
// Shared widths, constants, roll/yaw term struct and arctangent table
// for the quaternion to Euler angle core. No dependencies.
package qe_pkg;

   // Pipeline lengths and lane count
   localparam int QE_CORDIC_STEPS = 16;
   localparam int QE_SQRT_STEPS   = 26;
   localparam int QE_LANES        = 3;

   // Word widths along the datapath
   localparam int QE_COMP_W = 16;
   localparam int QE_PROD_W = 32;
   localparam int QE_TERM_W = 34;
   localparam int QE_RAD_W  = 50;
   localparam int QE_ROOT_W = 25;
   localparam int QE_VEC_W  = 36;
   localparam int QE_ANG_W  = 28;

   localparam logic signed [QE_TERM_W-1:0] QE_ONE_Q28  = 34'sd268435456;
   localparam logic signed [QE_ANG_W-1:0]  QE_HALF_PI  = 28'sd26353589;
   localparam int                          QE_ROLL_LIM  = 12868;
   localparam int                          QE_PITCH_LIM = 6434;

   // Terms for roll and yaw, carried alongside the square root pipeline
   typedef struct packed {
      logic                          clamped;
      logic signed [QE_TERM_W-1:0]   sr;
      logic signed [QE_TERM_W-1:0]   cr;
      logic signed [QE_TERM_W-1:0]   sy;
      logic signed [QE_TERM_W-1:0]   cy;
   } qe_trig_type;

   // atan(2^-i) at 2^24 rad, rounded to nearest
   function automatic logic signed [QE_ANG_W-1:0] qe_atan(input int idx);
      logic signed [QE_ANG_W-1:0] v;
      case (idx)
         0:  v = 28'sd13176795;
         1:  v = 28'sd7778716;
         2:  v = 28'sd4110060;
         3:  v = 28'sd2086331;
         4:  v = 28'sd1047214;
         5:  v = 28'sd524117;
         6:  v = 28'sd262123;
         7:  v = 28'sd131069;
         8:  v = 28'sd65536;
         9:  v = 28'sd32768;
         10: v = 28'sd16384;
         11: v = 28'sd8192;
         12: v = 28'sd4096;
         13: v = 28'sd2048;
         14: v = 28'sd1024;
         15: v = 28'sd512;
         16: v = 28'sd256;
         17: v = 28'sd128;
         18: v = 28'sd64;
         19: v = 28'sd32;
         20: v = 28'sd16;
         21: v = 28'sd8;
         22: v = 28'sd4;
         23: v = 28'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> src/qe_front.sv
// Front end: component products, then the sine/cosine terms and clamped
// radicands for pitch. Two register stages. Depends on qe_pkg.
module qe_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic signed [qe_pkg::QE_COMP_W-1:0]   qx,
   input  logic signed [qe_pkg::QE_COMP_W-1:0]   qy,
   input  logic signed [qe_pkg::QE_COMP_W-1:0]   qz,
   input  logic signed [qe_pkg::QE_COMP_W-1:0]   qw,
   output logic                                  out_valid,
   output qe_pkg::qe_trig_type                   out_trig,
   output logic [qe_pkg::QE_RAD_W-1:0]           out_rad_p,
   output logic [qe_pkg::QE_RAD_W-1:0]           out_rad_m
);
   import qe_pkg::*;

   logic [1:0] vld_ff;
   logic signed [QE_PROD_W-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wz_ff, xy_ff, zz_ff, wy_ff, xz_ff;
   logic signed [QE_TERM_W-1:0] s_in, s_c;
   logic signed [QE_TERM_W-1:0] sum_p, sum_m;
   qe_trig_type                 trig_in, trig_ff;
   logic [QE_RAD_W-1:0]         rad_p_in, rad_m_in, rad_p_ff, rad_m_ff;

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[0], in_valid};
      end
   end

   // Stage one: the nine products, exact at 2^28
   always_ff @(posedge clock) begin
      wx_ff <= qw * qx;
      yz_ff <= qy * qz;
      xx_ff <= qx * qx;
      yy_ff <= qy * qy;
      wz_ff <= qw * qz;
      xy_ff <= qx * qy;
      zz_ff <= qz * qz;
      wy_ff <= qw * qy;
      xz_ff <= qx * qz;
   end

   // Stage two: terms, clamp the pitch sine and form both radicands
   always_comb begin
      trig_in.sr = (QE_TERM_W'(wx_ff) + QE_TERM_W'(yz_ff)) <<< 1;
      trig_in.cr = QE_ONE_Q28 - ((QE_TERM_W'(xx_ff) + QE_TERM_W'(yy_ff)) <<< 1);
      trig_in.sy = (QE_TERM_W'(wz_ff) + QE_TERM_W'(xy_ff)) <<< 1;
      trig_in.cy = QE_ONE_Q28 - ((QE_TERM_W'(yy_ff) + QE_TERM_W'(zz_ff)) <<< 1);
      s_in = (QE_TERM_W'(wy_ff) - QE_TERM_W'(xz_ff)) <<< 1;
      trig_in.clamped = 1'b0;
      s_c = s_in;
      if (s_in > QE_ONE_Q28) begin
         s_c = QE_ONE_Q28;
         trig_in.clamped = 1'b1;
      end else if (s_in < -QE_ONE_Q28) begin
         s_c = -QE_ONE_Q28;
         trig_in.clamped = 1'b1;
      end
      sum_p = QE_ONE_Q28 + s_c;
      sum_m = QE_ONE_Q28 - s_c;
      rad_p_in = {sum_p[29:0], 20'd0};
      rad_m_in = {sum_m[29:0], 20'd0};
   end

   always_ff @(posedge clock) begin
      trig_ff  <= trig_in;
      rad_p_ff <= rad_p_in;
      rad_m_ff <= rad_m_in;
   end

   assign out_valid = vld_ff[1];
   assign out_trig  = trig_ff;
   assign out_rad_p = rad_p_ff;
   assign out_rad_m = rad_m_ff;

endmodule

>>> src/qe_sqrt.sv
// Two-lane restoring square root, one result bit per register stage, with
// the roll/yaw terms carried alongside. Depends on qe_pkg.
module qe_sqrt (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic [qe_pkg::QE_RAD_W-1:0]           in_rad [2],
   input  qe_pkg::qe_trig_type                   in_trig,
   output logic                                  out_valid,
   output logic [qe_pkg::QE_ROOT_W-1:0]          out_root [2],
   output qe_pkg::qe_trig_type                   out_trig
);
   import qe_pkg::*;

   localparam int SQ = QE_SQRT_STEPS;

   logic [SQ-1:0]       vld_ff, vld_in;
   qe_trig_type         trig_ff [SQ];
   qe_trig_type         trig_in [SQ];
   logic [QE_RAD_W-1:0] a_ff [2][SQ-1];
   logic [QE_RAD_W-1:0] a_in [2][SQ-1];
   logic [QE_RAD_W:0]   r_ff [2][SQ];
   logic [QE_RAD_W:0]   r_in [2][SQ];

   // One trial subtraction per stage; the bit walks down from 2^50
   always_comb begin
      logic [QE_RAD_W+1:0] bitv, trial;
      logic [QE_RAD_W-1:0] a_cur, a_next;
      logic [QE_RAD_W:0]   r_cur, r_next;
      vld_in = {vld_ff[SQ-2:0], in_valid};
      trig_in[0] = in_trig;
      for (int k = 1; k < SQ; k++) begin
         trig_in[k] = trig_ff[k-1];
      end
      for (int l = 0; l < 2; l++) begin
         for (int k = 0; k < SQ; k++) begin
            bitv = (QE_RAD_W+2)'(1) << (QE_RAD_W - 2*k);
            if (k == 0) begin
               a_cur = in_rad[l];
               r_cur = '0;
            end else begin
               a_cur = a_ff[l][k-1];
               r_cur = r_ff[l][k-1];
            end
            trial = {1'b0, r_cur} + bitv;
            if ({2'b00, a_cur} >= trial) begin
               a_next = a_cur - trial[QE_RAD_W-1:0];
               r_next = (r_cur >> 1) + bitv[QE_RAD_W:0];
            end else begin
               a_next = a_cur;
               r_next = r_cur >> 1;
            end
            r_in[l][k] = r_next;
            if (k < SQ-1) begin
               a_in[l][k] = a_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      trig_ff <= trig_in;
      a_ff    <= a_in;
      r_ff    <= r_in;
   end

   assign out_valid   = vld_ff[SQ-1];
   assign out_trig    = trig_ff[SQ-1];
   assign out_root[0] = r_ff[0][SQ-1][QE_ROOT_W-1:0];
   assign out_root[1] = r_ff[1][SQ-1][QE_ROOT_W-1:0];

endmodule

>>> src/qe_cordic.sv
// Three-lane vectoring CORDIC arctangent: a quadrant fold stage, then one
// micro-rotation per register stage. Depends on qe_pkg.
module qe_cordic #(
   parameter int STEPS = qe_pkg::QE_CORDIC_STEPS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic signed [qe_pkg::QE_VEC_W-1:0]    in_y [qe_pkg::QE_LANES],
   input  logic signed [qe_pkg::QE_VEC_W-1:0]    in_x [qe_pkg::QE_LANES],
   input  logic                                  in_clamped,
   output logic                                  out_valid,
   output logic signed [qe_pkg::QE_ANG_W-1:0]    out_z [qe_pkg::QE_LANES],
   output logic                                  out_clamped
);
   import qe_pkg::*;

   logic [STEPS:0]              vld_ff, vld_in, clp_ff, clp_in;
   logic signed [QE_VEC_W-1:0]  x_ff [QE_LANES][STEPS];
   logic signed [QE_VEC_W-1:0]  x_in [QE_LANES][STEPS];
   logic signed [QE_VEC_W-1:0]  y_ff [QE_LANES][STEPS];
   logic signed [QE_VEC_W-1:0]  y_in [QE_LANES][STEPS];
   logic signed [QE_ANG_W-1:0]  z_ff [QE_LANES][STEPS+1];
   logic signed [QE_ANG_W-1:0]  z_in [QE_LANES][STEPS+1];
   logic                        zero_ff [QE_LANES][STEPS+1];
   logic                        zero_in [QE_LANES][STEPS+1];

   always_comb begin
      logic signed [QE_VEC_W-1:0] dx, dy;
      vld_in = {vld_ff[STEPS-1:0], in_valid};
      clp_in = {clp_ff[STEPS-1:0], in_clamped};
      for (int l = 0; l < QE_LANES; l++) begin
         // Fold the left half-plane by a quarter turn; mark the null vector
         zero_in[l][0] = (in_x[l] == 0) && (in_y[l] == 0);
         if (in_x[l] < 0) begin
            if (in_y[l] >= 0) begin
               x_in[l][0] = in_y[l];
               y_in[l][0] = -in_x[l];
               z_in[l][0] = QE_HALF_PI;
            end else begin
               x_in[l][0] = -in_y[l];
               y_in[l][0] = in_x[l];
               z_in[l][0] = -QE_HALF_PI;
            end
         end else begin
            x_in[l][0] = in_x[l];
            y_in[l][0] = in_y[l];
            z_in[l][0] = '0;
         end
         // Rotate towards the x axis, accumulating the angle
         for (int i = 0; i < STEPS; i++) begin
            dx = y_ff[l][i] >>> i;
            dy = x_ff[l][i] >>> i;
            zero_in[l][i+1] = zero_ff[l][i];
            if (y_ff[l][i] >= 0) begin
               z_in[l][i+1] = z_ff[l][i] + qe_atan(i);
               if (i < STEPS-1) begin
                  x_in[l][i+1] = x_ff[l][i] + dx;
                  y_in[l][i+1] = y_ff[l][i] - dy;
               end
            end else begin
               z_in[l][i+1] = z_ff[l][i] - qe_atan(i);
               if (i < STEPS-1) begin
                  x_in[l][i+1] = x_ff[l][i] - dx;
                  y_in[l][i+1] = y_ff[l][i] + dy;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      clp_ff  <= clp_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      zero_ff <= zero_in;
   end

   // Drop the accumulated angle for a null vector
   always_comb begin
      for (int l = 0; l < QE_LANES; l++) begin
         out_z[l] = zero_ff[l][STEPS] ? '0 : z_ff[l][STEPS];
      end
   end

   assign out_valid   = vld_ff[STEPS];
   assign out_clamped = clp_ff[STEPS];

endmodule

>>> src/quaternion_to_euler_angles_core.sv
// Quaternion (Q1.14) to Z-Y-X Euler angles (roll, yaw Q2.12; pitch Q1.12): top level.
// Depends on qe_pkg, qe_front, qe_sqrt and qe_cordic.
//
// Takes one quaternion per clock and returns roll, pitch and yaw after the
// product and term stages, the bit-per-stage square root, one quadrant fold,
// one CORDIC micro-rotation per stage, and one output register.
// busy is high only during reset; otherwise a request is taken every cycle.
// Each result is shown for one cycle with rsp_valid and cannot be held off.
// rsp_pitch_clamped marks a non-unit quaternion whose pitch sine was clamped.
module quaternion_to_euler_angles_core #(
   parameter int CORDIC_STEPS = qe_pkg::QE_CORDIC_STEPS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [qe_pkg::QE_COMP_W-1:0]   req_qx,
   input  logic signed [qe_pkg::QE_COMP_W-1:0]   req_qy,
   input  logic signed [qe_pkg::QE_COMP_W-1:0]   req_qz,
   input  logic signed [qe_pkg::QE_COMP_W-1:0]   req_qw,
   output logic                                  rsp_valid,
   output logic signed [14:0]                    rsp_roll,
   output logic signed [13:0]                    rsp_pitch,
   output logic signed [14:0]                    rsp_yaw,
   output logic                                  rsp_pitch_clamped
);
   import qe_pkg::*;

   localparam logic signed [16:0] ROLL_HI  = 17'(QE_ROLL_LIM);
   localparam logic signed [17:0] PITCH_HI = 18'(QE_PITCH_LIM);

   logic                         fr_valid, sq_valid, co_valid, co_clamped;
   qe_trig_type                  fr_trig, sq_trig;
   logic [QE_RAD_W-1:0]          fr_rad [2];
   logic [QE_ROOT_W-1:0]         sq_root [2];
   logic signed [QE_VEC_W-1:0]   co_y [QE_LANES];
   logic signed [QE_VEC_W-1:0]   co_x [QE_LANES];
   logic signed [QE_ANG_W-1:0]   co_z [QE_LANES];

   logic signed [QE_ANG_W:0]     roll_r, yaw_r, pitch_a;
   logic signed [QE_ANG_W+1:0]   pitch_r;
   logic signed [16:0]           roll_q, yaw_q;
   logic signed [17:0]           pitch_q;
   logic signed [14:0]           roll_in, yaw_in, roll_ff, yaw_ff;
   logic signed [13:0]           pitch_in, pitch_ff;
   logic                         valid_ff, clamped_ff;

   // Hold requests off only while in reset
   assign busy = reset;

   qe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .qx        (req_qx),
      .qy        (req_qy),
      .qz        (req_qz),
      .qw        (req_qw),
      .out_valid (fr_valid),
      .out_trig  (fr_trig),
      .out_rad_p (fr_rad[0]),
      .out_rad_m (fr_rad[1])
   );

   qe_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_rad    (fr_rad),
      .in_trig   (fr_trig),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_trig  (sq_trig)
   );

   // Lanes: roll, yaw, pitch
   always_comb begin
      co_y[0] = QE_VEC_W'(sq_trig.sr);
      co_x[0] = QE_VEC_W'(sq_trig.cr);
      co_y[1] = QE_VEC_W'(sq_trig.sy);
      co_x[1] = QE_VEC_W'(sq_trig.cy);
      co_y[2] = $signed({{(QE_VEC_W-QE_ROOT_W){1'b0}}, sq_root[0]});
      co_x[2] = $signed({{(QE_VEC_W-QE_ROOT_W){1'b0}}, sq_root[1]});
   end

   qe_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (sq_valid),
      .in_y        (co_y),
      .in_x        (co_x),
      .in_clamped  (sq_trig.clamped),
      .out_valid   (co_valid),
      .out_z       (co_z),
      .out_clamped (co_clamped)
   );

   // Round to Q2.12 (roll, yaw) and Q1.12 (pitch) and saturate each angle
   always_comb begin
      roll_r  = (QE_ANG_W+1)'(co_z[0]) + 29'sd2048;
      yaw_r   = (QE_ANG_W+1)'(co_z[1]) + 29'sd2048;
      pitch_a = ((QE_ANG_W+1)'(co_z[2]) <<< 1) - (QE_ANG_W+1)'(QE_HALF_PI);
      pitch_r = (QE_ANG_W+2)'(pitch_a) + 30'sd2048;
      roll_q  = roll_r[QE_ANG_W:12];
      yaw_q   = yaw_r[QE_ANG_W:12];
      pitch_q = pitch_r[QE_ANG_W+1:12];
      if (roll_q > ROLL_HI)       roll_in = 15'(ROLL_HI);
      else if (roll_q < -ROLL_HI) roll_in = 15'(-ROLL_HI);
      else                        roll_in = roll_q[14:0];
      if (yaw_q > ROLL_HI)        yaw_in = 15'(ROLL_HI);
      else if (yaw_q < -ROLL_HI)  yaw_in = 15'(-ROLL_HI);
      else                        yaw_in = yaw_q[14:0];
      if (pitch_q > PITCH_HI)       pitch_in = 14'(PITCH_HI);
      else if (pitch_q < -PITCH_HI) pitch_in = 14'(-PITCH_HI);
      else                          pitch_in = pitch_q[13:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= co_valid;
      end
   end

   always_ff @(posedge clock) begin
      roll_ff    <= roll_in;
      yaw_ff     <= yaw_in;
      pitch_ff   <= pitch_in;
      clamped_ff <= co_clamped;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_roll          = roll_ff;
   assign rsp_yaw           = yaw_ff;
   assign rsp_pitch         = pitch_ff;
   assign rsp_pitch_clamped = clamped_ff;

endmodule

>>> src/qe_checker.sv
// Port-level checks for the quaternion to Euler angle core, and the bind
// that attaches them. Depends on qe_pkg and the top level.
module qe_port_checks #(
   parameter int CORDIC_STEPS = qe_pkg::QE_CORDIC_STEPS
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [14:0] rsp_roll,
   input logic signed [13:0] rsp_pitch,
   input logic signed [14:0] rsp_yaw
);
   import qe_pkg::*;

   localparam int LAT = 2 + QE_SQRT_STEPS + 1 + CORDIC_STEPS + 1;

   // Every accepted request comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("request lost in pipeline");

   // No result without a request that far back
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without request");

   // Nothing comes out in the cycle after reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result straight after reset");

   // Angles stay in their ranges
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll <= 15'sd12868 && rsp_roll >= -15'sd12868 &&
                     rsp_yaw <= 15'sd12868 && rsp_yaw >= -15'sd12868 &&
                     rsp_pitch <= 14'sd6434 && rsp_pitch >= -14'sd6434))
      else $error("angle out of range");

endmodule

bind quaternion_to_euler_angles_core qe_port_checks #(.CORDIC_STEPS(CORDIC_STEPS)) u_qe_checks (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_roll  (rsp_roll),
   .rsp_pitch (rsp_pitch),
   .rsp_yaw   (rsp_yaw)
);
